FILE: hw/rtl/u8v_pkg.sv
// ----------------------------------------------------------------------------
// u8v_pkg
// Shared types and constants of the UTF-8 stream validator.
// ----------------------------------------------------------------------------
package u8v_pkg;

    // Byte ranges for lead bytes
    localparam logic [7:0] LEAD_ASCII_MAX = 8'h7F;
    localparam logic [7:0] LEAD2_MIN      = 8'hC2;
    localparam logic [7:0] LEAD2_MAX      = 8'hDF;
    localparam logic [7:0] LEAD3_MIN      = 8'hE0;
    localparam logic [7:0] LEAD3_MAX      = 8'hEF;
    localparam logic [7:0] LEAD4_MIN      = 8'hF0;
    localparam logic [7:0] LEAD4_MAX      = 8'hF4;

    // Continuation byte tag: 10xxxxxx
    localparam logic [7:0] CONT_MASK      = 8'hC0;
    localparam logic [7:0] CONT_TAG       = 8'h80;

    // Code point limits
    localparam int unsigned CODE_W        = 21;
    localparam logic [CODE_W-1:0]  MIN_THREE     = 21'h000800;
    localparam logic [CODE_W-1:0]  MIN_FOUR      = 21'h010000;
    localparam logic [CODE_W-1:0]  MAX_CODE      = 21'h10FFFF;
    localparam logic [CODE_W-12:0] SURROGATE_TOP = 10'h01B;

    // Sequence lengths and pending counts
    localparam logic [2:0] SEQ_NONE  = 3'd0;
    localparam logic [2:0] SEQ_TWO   = 3'd2;
    localparam logic [2:0] SEQ_THREE = 3'd3;
    localparam logic [2:0] SEQ_FOUR  = 3'd4;

    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_ONE   = 2'd1;
    localparam logic [1:0] PEND_TWO   = 2'd2;
    localparam logic [1:0] PEND_THREE = 2'd3;

    // Depth of the queue between front and back
    localparam int unsigned U8V_QUEUE_DEPTH = 2;

    // How a byte reads when it stands where a lead is expected
    typedef enum logic [2:0] {
        LK_ASCII,
        LK_TWO,
        LK_THREE,
        LK_FOUR,
        LK_BAD
    } lead_kind_t;

    // One classified byte
    typedef struct packed {
        lead_kind_t  kind;
        logic [4:0]  lead_bits;
        logic        is_cont;
        logic [5:0]  cont_bits;
        logic        last;
    } u8v_item_t;

endpackage

FILE: hw/rtl/u8v_front.sv
// ----------------------------------------------------------------------------
// u8v_front
// Accepts input words and classifies each byte as lead or continuation.
// ----------------------------------------------------------------------------
module u8v_front
    import u8v_pkg::*;
(
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       q_full,
    output logic       push,
    output u8v_item_t  push_item
);

    lead_kind_t kind;
    logic [4:0] lead_bits;

    always_comb
    begin
        kind      = LK_BAD;
        lead_bits = 5'd0;
        if (data_byte <= LEAD_ASCII_MAX)
        begin
            kind = LK_ASCII;
        end
        else if (data_byte >= LEAD2_MIN && data_byte <= LEAD2_MAX)
        begin
            kind      = LK_TWO;
            lead_bits = data_byte[4:0];
        end
        else if (data_byte >= LEAD3_MIN && data_byte <= LEAD3_MAX)
        begin
            kind      = LK_THREE;
            lead_bits = {1'b0, data_byte[3:0]};
        end
        else if (data_byte >= LEAD4_MIN && data_byte <= LEAD4_MAX)
        begin
            kind      = LK_FOUR;
            lead_bits = {2'b00, data_byte[2:0]};
        end
    end

    assign s_tready            = !q_full;
    assign push                = s_tvalid && !q_full;
    assign push_item.kind      = kind;
    assign push_item.lead_bits = lead_bits;
    assign push_item.is_cont   = (data_byte & CONT_MASK) == CONT_TAG;
    assign push_item.cont_bits = data_byte[5:0];
    assign push_item.last      = last_byte;

endmodule

FILE: hw/rtl/u8v_queue.sv
// ----------------------------------------------------------------------------
// u8v_queue
// Short FIFO of classified bytes between the front and the back.
// ----------------------------------------------------------------------------
module u8v_queue
    import u8v_pkg::*;
#(
    parameter int unsigned DEPTH = U8V_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  u8v_item_t push_item,
    output logic      full,
    input  logic      pop,
    output u8v_item_t pop_item,
    output logic      not_empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    u8v_item_t         slot_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg,  count_next;
    logic              do_push, do_pop;

    assign full      = count_reg == CW'(DEPTH);
    assign not_empty = count_reg != '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: hw/rtl/u8v_back.sv
// ----------------------------------------------------------------------------
// u8v_back
// Tracks open sequences, gathers code points and registers the verdict.
// ----------------------------------------------------------------------------
module u8v_back
    import u8v_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  u8v_item_t item,
    output logic      pop,
    output logic      m_valid,
    input  logic      m_ready,
    output logic      is_valid
);

    logic [1:0]        pending_reg, pending_next;
    logic [2:0]        seq_len_reg, seq_len_next;
    logic [CODE_W-1:0] acc_reg,     acc_next;
    logic              err_reg,     err_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_data_reg,  out_data_next;
    logic [CODE_W-1:0] acc_shift;
    logic              verdict;

    // Hold a last byte while an unread verdict still sits in the output
    assign pop       = q_valid && (!item.last || !out_valid_reg || m_ready);
    assign acc_shift = {acc_reg[CODE_W-7:0], item.cont_bits};
    assign m_valid   = out_valid_reg;
    assign is_valid  = out_data_reg;

    always_comb
    begin
        pending_next   = pending_reg;
        seq_len_next   = seq_len_reg;
        acc_next       = acc_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        verdict        = 1'b0;

        if (pop)
        begin
            if (pending_reg == PEND_NONE)
            begin
                unique case (item.kind)
                    LK_ASCII:
                    begin
                    end
                    LK_TWO:
                    begin
                        seq_len_next = SEQ_TWO;
                        pending_next = PEND_ONE;
                        acc_next     = CODE_W'(item.lead_bits);
                    end
                    LK_THREE:
                    begin
                        seq_len_next = SEQ_THREE;
                        pending_next = PEND_TWO;
                        acc_next     = CODE_W'(item.lead_bits);
                    end
                    LK_FOUR:
                    begin
                        seq_len_next = SEQ_FOUR;
                        pending_next = PEND_THREE;
                        acc_next     = CODE_W'(item.lead_bits);
                    end
                    default:
                    begin
                        err_next = 1'b1;
                    end
                endcase
            end
            else if (!item.is_cont)
            begin
                // Drop the open sequence
                err_next     = 1'b1;
                pending_next = PEND_NONE;
                seq_len_next = SEQ_NONE;
                acc_next     = '0;
            end
            else
            begin
                acc_next     = acc_shift;
                pending_next = pending_reg - 1'b1;
                if (pending_reg == PEND_ONE)
                begin
                    if (seq_len_reg == SEQ_THREE)
                    begin
                        if (acc_shift < MIN_THREE
                            || acc_shift[CODE_W-1:11] == SURROGATE_TOP)
                        begin
                            err_next = 1'b1;
                        end
                    end
                    else if (seq_len_reg == SEQ_FOUR)
                    begin
                        if (acc_shift < MIN_FOUR || acc_shift > MAX_CODE)
                        begin
                            err_next = 1'b1;
                        end
                    end
                    seq_len_next = SEQ_NONE;
                    acc_next     = '0;
                end
            end

            if (item.last)
            begin
                verdict        = !err_next && (pending_next == PEND_NONE);
                out_valid_next = 1'b1;
                out_data_next  = verdict;
                pending_next   = PEND_NONE;
                seq_len_next   = SEQ_NONE;
                acc_next       = '0;
                err_next       = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= PEND_NONE;
            seq_len_reg   <= SEQ_NONE;
            acc_reg       <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pending_reg   <= pending_next;
            seq_len_reg   <= seq_len_next;
            acc_reg       <= acc_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    // No sequence open means nothing gathered
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == PEND_NONE |-> seq_len_reg == SEQ_NONE && acc_reg == '0)
        else $error("pending count is zero but sequence state is not clear");

    // An open sequence is always longer than what it still expects
    a_len_covers: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != PEND_NONE |-> seq_len_reg > {1'b0, pending_reg})
        else $error("sequence length does not cover pending bytes");

    // A consumed last byte leaves a verdict and a clean state
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        pop && item.last |=> out_valid_reg && pending_reg == PEND_NONE && !err_reg)
        else $error("last byte did not produce a verdict or clear state");

    // Never overwrite a verdict that has not been taken
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_ready |-> !(pop && item.last))
        else $error("verdict overwritten before it was taken");

endmodule

FILE: hw/rtl/utf8_stream_validator.sv
// ----------------------------------------------------------------------------
// utf8_stream_validator
// Checks a byte stream for well-formed UTF-8, one verdict per buffer.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_axis    in   s_tvalid/s_tready  s_tdata[7:0] = data_byte, s_tlast = last_byte
//  m_axis    out  m_tvalid/m_tready  m_tdata[0] = is_valid, [7:1] zero
//
//  One byte per cycle sustained while the output keeps up and the queue
//  has room; the front classifies, a short queue feeds the back, which
//  registers the sequence state. m_tvalid rises once the last byte has
//  been written into the queue and the back has popped it and registered
//  its verdict. Reset clears the queue, the sequence state and the output
//  valid flag. A stalled output holds the back only on the next last byte;
//  the queue absorbs the stall and s_tready drops once it is full.
// ----------------------------------------------------------------------------
module utf8_stream_validator
    import u8v_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = U8V_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] is_valid, [7:1] zero
);

    u8v_item_t push_item, pop_item;
    logic      push, q_full, pop, q_valid, is_valid;

    u8v_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    u8v_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .not_empty (q_valid)
    );

    u8v_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .item     (pop_item),
        .pop      (pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .is_valid (is_valid)
    );

    assign m_tdata = {7'b0, is_valid};

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams byte buffers into utf8_stream_validator and checks each verdict
// against the table or a cycle-free decoder of its own. A short table covers
// lead and continuation corner cases; random, mostly well-formed UTF-8
// buffers with occasional damage follow; input is bursty, output stalls.
// ----------------------------------------------------------------------------
module testbench;
    import u8v_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned RANDOM_ITEMS = 600;
    localparam int unsigned HOLD_CYCLES  = 80;
    localparam int unsigned DRAIN_CYCLES = 12;

    localparam logic VERDICT_BAD = 1'b0;
    localparam logic VERDICT_OK  = 1'b1;

    // Lead byte tags used when encoding random code points
    localparam logic [7:0] TAG_TWO   = 8'hC0;
    localparam logic [7:0] TAG_THREE = 8'hE0;
    localparam logic [7:0] TAG_FOUR  = 8'hF0;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       fixed;
        logic       verdict;
    } byte_row_t;

    localparam int unsigned ROWS = 24;

    byte_row_t byte_rows [0:ROWS-1] = '{
        '{8'h00, 1'b1, 1'b1, VERDICT_OK},
        '{8'hFF, 1'b1, 1'b1, VERDICT_BAD},
        '{8'hC2, 1'b0, 1'b0, VERDICT_BAD},
        '{8'h80, 1'b1, 1'b1, VERDICT_OK},
        // overlong three-byte form
        '{8'hE0, 1'b0, 1'b0, VERDICT_BAD},
        '{8'h9F, 1'b0, 1'b0, VERDICT_BAD},
        '{8'hBF, 1'b1, 1'b1, VERDICT_BAD},
        // surrogate
        '{8'hED, 1'b0, 1'b0, VERDICT_BAD},
        '{8'hA0, 1'b0, 1'b0, VERDICT_BAD},
        '{8'h80, 1'b1, 1'b1, VERDICT_BAD},
        // above the code space
        '{8'hF4, 1'b0, 1'b0, VERDICT_BAD},
        '{8'h90, 1'b0, 1'b0, VERDICT_BAD},
        '{8'h80, 1'b0, 1'b0, VERDICT_BAD},
        '{8'h80, 1'b1, 1'b1, VERDICT_BAD},
        // ASCII then the highest code point
        '{8'h7F, 1'b0, 1'b0, VERDICT_BAD},
        '{8'hF4, 1'b0, 1'b0, VERDICT_BAD},
        '{8'h8F, 1'b0, 1'b0, VERDICT_BAD},
        '{8'hBF, 1'b0, 1'b0, VERDICT_BAD},
        '{8'hBF, 1'b1, 1'b0, VERDICT_BAD},
        // bad continuation, the byte is not retried as a lead
        '{8'hC2, 1'b0, 1'b0, VERDICT_BAD},
        '{8'h41, 1'b1, 1'b1, VERDICT_BAD},
        // sequence cut off by the last byte
        '{8'hE0, 1'b1, 1'b1, VERDICT_BAD},
        // error stays sticky while decoding goes on
        '{8'h80, 1'b0, 1'b0, VERDICT_BAD},
        '{8'h41, 1'b1, 1'b1, VERDICT_BAD}
    };

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] data_byte
    logic       s_tlast  = 1'b0;    // last_byte
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [0] is_valid, [7:1] zero

    // decoder state
    logic [1:0]  pend_cnt = PEND_NONE;
    logic [2:0]  seq_len  = SEQ_NONE;
    logic [20:0] code_acc = '0;
    logic        err_flag = 1'b0;

    logic        verdict_q [$];
    logic [7:0]  frame_q [$];
    logic        want_verdict;
    int unsigned mismatches   = 0;
    int unsigned bytes_sent   = 0;
    int unsigned burst_left   = 0;
    int unsigned cycle_count  = 0;
    bit          hold_off_req = 1'b0;

    utf8_stream_validator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // Advance the decoder by one byte; done marks a buffer verdict.
    task automatic absorb_byte(input logic [7:0] b, input logic last,
                               output logic done, output logic verdict);
        done    = 1'b0;
        verdict = VERDICT_BAD;
        if (pend_cnt == PEND_NONE) begin
            if (b <= LEAD_ASCII_MAX) begin
            end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
                seq_len  = SEQ_TWO;
                pend_cnt = PEND_ONE;
                code_acc = {16'b0, b[4:0]};
            end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
                seq_len  = SEQ_THREE;
                pend_cnt = PEND_TWO;
                code_acc = {17'b0, b[3:0]};
            end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
                seq_len  = SEQ_FOUR;
                pend_cnt = PEND_THREE;
                code_acc = {18'b0, b[2:0]};
            end else begin
                err_flag = 1'b1;
            end
        end else if ((b & CONT_MASK) != CONT_TAG) begin
            // drop the open sequence
            err_flag = 1'b1;
            pend_cnt = PEND_NONE;
            seq_len  = SEQ_NONE;
            code_acc = '0;
        end else begin
            code_acc = {code_acc[14:0], b[5:0]};
            pend_cnt = pend_cnt - 2'd1;
            if (pend_cnt == PEND_NONE) begin
                if (seq_len == SEQ_THREE) begin
                    if (code_acc < MIN_THREE || code_acc[20:11] == SURROGATE_TOP)
                        err_flag = 1'b1;
                end else if (seq_len == SEQ_FOUR) begin
                    if (code_acc < MIN_FOUR || code_acc > MAX_CODE)
                        err_flag = 1'b1;
                end
                seq_len  = SEQ_NONE;
                code_acc = '0;
            end
        end
        if (last) begin
            if (pend_cnt != PEND_NONE)
                err_flag = 1'b1;
            done     = 1'b1;
            verdict  = err_flag ? VERDICT_BAD : VERDICT_OK;
            pend_cnt = PEND_NONE;
            seq_len  = SEQ_NONE;
            code_acc = '0;
            err_flag = 1'b0;
        end
    endtask

    // Bursts of back-to-back words, then a gap with junk on the bus.
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tlast  <= 1'($urandom);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(0, 16);
        end
    endtask

    task automatic send_byte(input logic [7:0] data, input logic last,
                             input logic fixed, input logic fixed_verdict);
        logic done;
        logic verdict;
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        absorb_byte(data, last, done, verdict);
        if (done)
            verdict_q.push_back(fixed ? fixed_verdict : verdict);
        bytes_sent++;
        pace_sender();
    endtask

    task automatic append_code(input logic [20:0] cp, input int unsigned len);
        case (len)
            1: frame_q.push_back({1'b0, cp[6:0]});
            2: begin
                frame_q.push_back(TAG_TWO | {3'b0, cp[10:6]});
                frame_q.push_back(CONT_TAG | {2'b0, cp[5:0]});
            end
            3: begin
                frame_q.push_back(TAG_THREE | {4'b0, cp[15:12]});
                frame_q.push_back(CONT_TAG | {2'b0, cp[11:6]});
                frame_q.push_back(CONT_TAG | {2'b0, cp[5:0]});
            end
            default: begin
                frame_q.push_back(TAG_FOUR | {5'b0, cp[20:18]});
                frame_q.push_back(CONT_TAG | {2'b0, cp[17:12]});
                frame_q.push_back(CONT_TAG | {2'b0, cp[11:6]});
                frame_q.push_back(CONT_TAG | {2'b0, cp[5:0]});
            end
        endcase
    endtask

    task automatic add_random_code();
        logic [20:0] cp;
        int unsigned len;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: cp = 21'($urandom_range(0, 'h7F));
            4, 5:       cp = 21'($urandom_range('h80, 'h7FF));
            6, 7:       cp = 21'($urandom_range('h800, 'hFFFF));
            8:          cp = 21'($urandom_range('h10000, 'h10FFFF));
            default: begin
                case ($urandom_range(0, 11))
                    0:       cp = 21'h7F;
                    1:       cp = 21'h80;
                    2:       cp = 21'h7FF;
                    3:       cp = 21'h800;
                    4:       cp = 21'hD7FF;
                    5:       cp = 21'hD800;
                    6:       cp = 21'hDFFF;
                    7:       cp = 21'hE000;
                    8:       cp = 21'hFFFF;
                    9:       cp = 21'h10000;
                    10:      cp = 21'h110000;
                    default: cp = 21'h1FFFFF;
                endcase
            end
        endcase
        if (cp < 21'h80)
            len = 1;
        else if (cp < 21'h800)
            len = 2;
        else if (cp < 21'h10000)
            len = 3;
        else
            len = 4;
        // occasional overlong encoding
        if (len < 4 && $urandom_range(0, 11) == 0)
            len++;
        append_code(cp, len);
    endtask

    task automatic send_random_frame();
        int unsigned n;
        int unsigned idx;
        frame_q.delete();
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 5);
            repeat (n) frame_q.push_back(8'($urandom));
        end else begin
            n = $urandom_range(1, 6);
            repeat (n) add_random_code();
            if ($urandom_range(0, 4) == 0) begin
                idx = $urandom_range(0, frame_q.size() - 1);
                case ($urandom_range(0, 2))
                    0: frame_q[idx] = 8'($urandom);
                    1: if (frame_q.size() > 1) void'(frame_q.pop_back());
                    default: frame_q.insert(idx, 8'($urandom));
                endcase
            end
        end
        for (int k = 0; k < frame_q.size(); k++)
            send_byte(frame_q[k], k == frame_q.size() - 1, 1'b0, VERDICT_BAD);
    endtask

    // Receiver: a changing stall pattern, plus one long hold-off on request.
    initial
    begin : receiver
        int unsigned mode;
        int unsigned mode_left;
        int unsigned phase;
        logic        ready;
        mode      = 0;
        mode_left = 0;
        phase     = 0;
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                phase++;
                case (mode)
                    0:       ready = 1'b1;
                    1:       ready = 1'($urandom);
                    2:       ready = (phase % 4) != 0;
                    default: ready = $urandom_range(0, 9) < 2;
                endcase
                m_tready <= ready;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch($sformatf("verdict %0b with none expected", m_tdata[0]));
            end else begin
                want_verdict = verdict_q.pop_front();
                if (m_tdata[0] !== want_verdict)
                    report_mismatch($sformatf("is_valid %0b, expected %0b",
                                              m_tdata[0], want_verdict));
            end
            if (m_tdata[7:1] !== 7'b0)
                report_mismatch($sformatf("pad bits %b not zero", m_tdata[7:1]));
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles", cycle_count);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin : stimulus
        bit hold_done;
        bit pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < ROWS; r++)
            send_byte(byte_rows[r].data, byte_rows[r].last,
                      byte_rows[r].fixed, byte_rows[r].verdict);

        while (bytes_sent < ROWS + RANDOM_ITEMS) begin
            if (!hold_done && bytes_sent >= ROWS + 200) begin
                hold_off_req = 1'b1;
                hold_done    = 1'b1;
                // keep offering so the queue fills and s_tready drops
                burst_left   = 150;
            end
            if (!pause_done && bytes_sent >= ROWS + 400) begin
                pause_done = 1'b1;
                s_tvalid <= 1'b0;
                while (verdict_q.size() != 0) @(posedge clk);
            end
            send_random_frame();
        end

        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (verdict_q.size() != 0)
            report_mismatch($sformatf("%0d verdicts never arrived", verdict_q.size()));
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
